// ===== hw/rtl/ubxte_pkg.sv =====
// Package for the UBX frame receiver with TIM-TP time extraction.
// Holds frame constants, status codes and the structs shared by the top level
// and the frame evaluation logic. No dependencies.
package ubxte_pkg;

    // default frame size limit in bytes
    localparam int MAX_FRAME_BYTES_DEF = 128;

    // widths of positions compared against the declared payload length
    localparam int CMP_W = 17;

    // framing bytes
    localparam logic [7:0] SYNC_ONE   = 8'hB5;
    localparam logic [7:0] SYNC_TWO   = 8'h62;
    localparam logic [7:0] NMEA_START = 8'h24;

    // TIM-TP message
    localparam logic [7:0]  CLASS_TIM      = 8'h0D;
    localparam logic [7:0]  ID_TP          = 8'h01;
    localparam logic [15:0] MIN_TP_PAYLOAD = 16'd14;

    // fixed byte positions inside a UBX frame
    localparam logic [CMP_W-1:0] POS_SECOND   = CMP_W'(1);
    localparam logic [CMP_W-1:0] POS_CLASS    = CMP_W'(2);
    localparam logic [CMP_W-1:0] POS_ID       = CMP_W'(3);
    localparam logic [CMP_W-1:0] POS_LEN_LO   = CMP_W'(4);
    localparam logic [CMP_W-1:0] POS_PAYLOAD  = CMP_W'(6);
    localparam logic [CMP_W-1:0] POS_TOW_LAST = CMP_W'(9);
    localparam logic [CMP_W-1:0] POS_WEEK_LO  = CMP_W'(18);
    localparam logic [CMP_W-1:0] POS_WEEK_HI  = CMP_W'(19);
    localparam logic [CMP_W-1:0] MIN_ANY_LEN  = CMP_W'(4);
    localparam logic [CMP_W-1:0] MIN_UBX_LEN  = CMP_W'(8);
    localparam logic [CMP_W-1:0] UBX_OVERHEAD = CMP_W'(8);
    localparam logic [CMP_W-1:0] CHECK_OFFSET = CMP_W'(6);
    localparam logic [CMP_W-1:0] CHECK_HI_OFS = CMP_W'(7);

    // time scaling
    localparam logic [55:0] GPS_EPOCH_US = 56'd315964766000000;
    localparam logic [47:0] US_PER_WEEK  = 48'd604800000000;
    localparam logic [17:0] US_PER_MS    = 18'd1000;

    // frame status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NMEA    = 3'd1,
        ST_SHORT   = 3'd2,
        ST_SYNC    = 3'd3,
        ST_OVERRUN = 3'd4,
        ST_CHECK   = 3'd5,
        ST_UNKNOWN = 3'd6
    } t_status;

    // fields captured while a frame streams in
    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  second_byte;
        logic [7:0]  class_byte;
        logic [7:0]  id_byte;
        logic [15:0] declared_length;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
        logic [15:0] received_checks;
        logic [55:0] timestamp_acc;
    } t_frame_state;

    // one report for a closed frame
    typedef struct packed {
        t_status     frame_status;
        logic [6:0]  frame_length;
        logic [7:0]  message_class;
        logic [7:0]  message_id;
        logic [15:0] payload_length;
        logic        time_valid;
        logic [55:0] gps_time_us;
    } t_result;

endpackage

// ===== hw/rtl/ubxte_report.sv =====
// Evaluation of a closed frame: sync, length and checksum checks, TIM-TP detection.
// Pure combinational logic; depends on ubxte_pkg.
module ubxte_report #(
    parameter int PW = 7
) (
    input  ubxte_pkg::t_frame_state i_state,
    input  logic [PW-1:0]           i_len,
    output ubxte_pkg::t_result      o_result
);
    import ubxte_pkg::*;

    logic [CMP_W-1:0] w_len;
    logic [CMP_W-1:0] w_need;
    logic             w_ubx;
    logic             w_time;
    t_status          w_status;

    assign w_len  = CMP_W'(i_len);
    assign w_need = CMP_W'(i_state.declared_length) + UBX_OVERHEAD;

    // status decision, order follows the check sequence
    always_comb begin
        w_ubx    = 1'b0;
        w_time   = 1'b0;
        w_status = ST_UNKNOWN;
        priority if (w_len < MIN_ANY_LEN) begin
            w_status = ST_SHORT;
        end else if (i_state.start_byte == SYNC_ONE) begin
            priority if (i_state.second_byte != SYNC_TWO) begin
                w_status = ST_SYNC;
            end else if (w_len < MIN_UBX_LEN) begin
                w_status = ST_SHORT;
            end else begin
                w_ubx = 1'b1;
                priority if (w_need > w_len) begin
                    w_status = ST_OVERRUN;
                end else if (i_state.received_checks[7:0] != i_state.sum_a ||
                             i_state.received_checks[15:8] != i_state.sum_b) begin
                    w_status = ST_CHECK;
                end else begin
                    w_status = ST_OK;
                    w_time   = (i_state.class_byte == CLASS_TIM) &&
                               (i_state.id_byte == ID_TP) &&
                               (i_state.declared_length >= MIN_TP_PAYLOAD);
                end
            end
        end else if (i_state.start_byte == NMEA_START) begin
            w_status = ST_NMEA;
        end else begin
            w_status = ST_UNKNOWN;
        end
    end

    // result fields, ubx fields zeroed for non-ubx outcomes
    always_comb begin
        o_result.frame_status   = w_status;
        o_result.frame_length   = 7'(i_len);
        o_result.message_class  = w_ubx ? i_state.class_byte : 8'd0;
        o_result.message_id     = w_ubx ? i_state.id_byte : 8'd0;
        o_result.payload_length = w_ubx ? i_state.declared_length : 16'd0;
        o_result.time_valid     = w_time;
        o_result.gps_time_us    = w_time ? i_state.timestamp_acc : 56'd0;
    end

endmodule

// ===== hw/rtl/ubx_frame_receiver_time_extract.sv =====
// A frame report is registered in the result register after its closing delimiter byte has
// passed the input register. Throughput: one byte
// per cycle; input is stalled only while a report at the output is not being taken.
// Reset (synchronous, active low) empties the frame buffer and both pipeline valids.
// Top level of the UBX/NMEA frame receiver; depends on ubxte_pkg and ubxte_report.
module ubx_frame_receiver_time_extract #(
    parameter int MAX_FRAME_BYTES = ubxte_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] frame_length, [14:7] message_class, [22:15] message_id,
    // [38:23] payload_length, [94:39] gps_time_us, [95] zero
    output logic [95:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser   // [2:0] frame_status, [3] time_valid
);
    import ubxte_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_BYTES);

    logic              w_advance;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic [PW-1:0]     r_pos;
    logic [PW-1:0]     n_pos;
    t_frame_state      r_st;
    t_frame_state      n_st;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_report;
    logic              w_item;
    logic              w_drop;
    logic              w_delim;
    logic              w_close;
    logic [PW-1:0]     w_p;
    logic [CMP_W-1:0]  w_pe;
    logic [CMP_W-1:0]  w_check_pos;
    logic [7:0]        w_sum_a;
    logic [17:0]       w_ms_term;
    logic [47:0]       w_week_term;
    logic [55:0]       w_ts_add;

    // pipeline moves whenever the result register is free or draining
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_advance) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // frame control decisions for the registered byte
    assign w_item      = r_in_valid && w_advance;
    assign w_drop      = ({1'b0, r_pos} + (PW + 1)'(1)) >= (PW + 1)'(MAX_FRAME_BYTES);
    assign w_delim     = (r_in_byte == SYNC_ONE) || (r_in_byte == NMEA_START);
    assign w_close     = w_delim && (r_pos != '0) && !w_drop;
    assign w_p         = w_close ? '0 : r_pos;
    assign w_pe        = CMP_W'(w_p);
    assign w_check_pos = CMP_W'(r_st.declared_length) + CHECK_OFFSET;

    // per-byte timestamp terms, weighted by the byte's place in its field
    assign w_sum_a     = r_st.sum_a + r_in_byte;
    assign w_ms_term   = 18'(r_in_byte) * US_PER_MS;
    assign w_week_term = 48'(r_in_byte) * US_PER_WEEK;

    always_comb begin
        priority if (w_pe == POS_PAYLOAD) begin
            w_ts_add = 56'(w_ms_term);
        end else if (w_pe == POS_PAYLOAD + CMP_W'(1)) begin
            w_ts_add = 56'(w_ms_term) << 8;
        end else if (w_pe == POS_PAYLOAD + CMP_W'(2)) begin
            w_ts_add = 56'(w_ms_term) << 16;
        end else if (w_pe == POS_TOW_LAST) begin
            w_ts_add = 56'(w_ms_term) << 24;
        end else if (w_pe == POS_WEEK_LO) begin
            w_ts_add = 56'(w_week_term);
        end else if (w_pe == POS_WEEK_HI) begin
            w_ts_add = 56'(w_week_term) << 8;
        end else begin
            w_ts_add = 56'd0;
        end
    end

    // frame capture: header fields, running checksum, check bytes, timestamp
    always_comb begin
        n_pos = r_pos;
        n_st  = r_st;
        if (w_item) begin
            if (w_drop) begin
                n_pos = '0;
            end else begin
                n_pos = w_p + PW'(1);
                priority if (w_p == '0) begin
                    n_st.start_byte      = r_in_byte;
                    n_st.second_byte     = 8'd0;
                    n_st.class_byte      = 8'd0;
                    n_st.id_byte         = 8'd0;
                    n_st.declared_length = 16'd0;
                    n_st.sum_a           = 8'd0;
                    n_st.sum_b           = 8'd0;
                    n_st.received_checks = 16'd0;
                    n_st.timestamp_acc   = GPS_EPOCH_US;
                end else if (w_pe == POS_SECOND) begin
                    n_st.second_byte = r_in_byte;
                end else if (w_pe < POS_PAYLOAD) begin
                    n_st.sum_a = w_sum_a;
                    n_st.sum_b = r_st.sum_b + w_sum_a;
                    priority if (w_pe == POS_CLASS) begin
                        n_st.class_byte = r_in_byte;
                    end else if (w_pe == POS_ID) begin
                        n_st.id_byte = r_in_byte;
                    end else if (w_pe == POS_LEN_LO) begin
                        n_st.declared_length[7:0] = r_in_byte;
                    end else begin
                        n_st.declared_length[15:8] = r_in_byte;
                    end
                end else begin
                    priority if (w_pe < w_check_pos) begin
                        n_st.sum_a = w_sum_a;
                        n_st.sum_b = r_st.sum_b + w_sum_a;
                    end else if (w_pe == w_check_pos) begin
                        n_st.received_checks[7:0] = r_in_byte;
                    end else if (w_pe == CMP_W'(r_st.declared_length) + CHECK_HI_OFS) begin
                        n_st.received_checks[15:8] = r_in_byte;
                    end else begin
                        n_st.received_checks = r_st.received_checks;
                    end
                    n_st.timestamp_acc = r_st.timestamp_acc + w_ts_add;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
    end

    // evaluation of the frame being closed
    ubxte_report #(
        .PW(PW)
    ) u_report (
        .i_state (r_st),
        .i_len   (r_pos),
        .o_result(w_report)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_item && w_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_item && w_close) begin
            r_out <= w_report;
        end
    end

    // output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.gps_time_us, r_out.payload_length,
                            r_out.message_id, r_out.message_class, r_out.frame_length};
    assign m_axis_tuser  = {r_out.time_valid, r_out.frame_status};

`ifndef SYNTHESIS
    // buffered count stays below the frame size limit
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_FRAME_BYTES - 1))
        else $error("frame position beyond limit");

    // a timestamp is only reported for a good TIM-TP frame
    a_time_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.time_valid) |->
            (r_out.frame_status == ST_OK && r_out.message_class == CLASS_TIM &&
             r_out.message_id == ID_TP && r_out.payload_length >= MIN_TP_PAYLOAD))
        else $error("time_valid on a frame that is not a good TIM-TP");

    // a new report needs a byte in the input register in the cycle before it rises
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("report without a byte behind it");
`endif

endmodule

// ===== verif/ubxte_frame_report_checker.sv =====
// Frame report checker for the UBX/NMEA frame receiver: follows the received byte stream,
// predicts the report of every closed frame and compares it with the output channel.
// Depends on ubxte_pkg for the status codes, the report struct and the framing bytes.
module ubxte_frame_report_checker #(
    parameter int MAX_BYTES = ubxte_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_data,     // [7:0] rx_byte
    input  logic        i_rep_valid,
    input  logic        i_rep_ready,
    // [6:0] frame_length, [14:7] message_class, [22:15] message_id,
    // [38:23] payload_length, [94:39] gps_time_us, [95] zero
    input  logic [95:0] i_rep_data,
    input  logic [3:0]  i_rep_user,    // [2:0] frame_status, [3] time_valid
    output int          o_fail_count,
    output int          o_pending
);

    import ubxte_pkg::*;

    // time scaling, kept apart from the package
    localparam longint unsigned EPOCH_OFFSET_US = 64'd315964766000000;
    localparam longint unsigned WEEK_US         = 64'd604800000000;
    localparam longint unsigned MS_US           = 64'd1000;

    // captured fields of the frame being received
    int unsigned frame_pos;
    logic [7:0]  first_byte;
    logic [7:0]  sync_byte;
    logic [7:0]  rx_class;
    logic [7:0]  msg_id;
    logic [15:0] decl_len;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [15:0] check_bytes;
    logic [31:0] tow_ms;
    logic [15:0] gps_week;

    t_result report_q[$];
    int      mismatch_total = 0;
    int      pending_reports = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = pending_reports;

    task automatic clear_capture();
        frame_pos   = 0;
        first_byte  = '0;
        sync_byte   = '0;
        rx_class    = '0;
        msg_id      = '0;
        decl_len    = '0;
        sum_a       = '0;
        sum_b       = '0;
        check_bytes = '0;
        tow_ms      = '0;
        gps_week    = '0;
    endtask

    task automatic fletcher_add(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endtask

    // store one byte at the current position and advance
    task automatic absorb_byte(input logic [7:0] b);
        int unsigned p;
        int unsigned d;
        p = frame_pos;
        d = 32'(decl_len);
        if (p == 0) begin
            clear_capture();
            first_byte = b;
        end else if (p == 1) begin
            sync_byte = b;
        end else if (p < 6) begin
            case (p)
                2: rx_class = b;
                3: msg_id = b;
                4: decl_len[7:0] = b;
                default: decl_len[15:8] = b;
            endcase
            fletcher_add(b);
        end else begin
            // checksum covers the declared payload, then the two check bytes follow
            if (p < d + 6)
                fletcher_add(b);
            else if (p == d + 6)
                check_bytes[7:0] = b;
            else if (p == d + 7)
                check_bytes[15:8] = b;
            // tim-tp fields sit at fixed payload offsets
            if (p <= 9)
                tow_ms[8*(p-6) +: 8] = b;
            else if (p == 18)
                gps_week[7:0] = b;
            else if (p == 19)
                gps_week[15:8] = b;
        end
        frame_pos = p + 1;
    endtask

    // evaluate the buffered frame
    function automatic t_result frame_report();
        t_result         r;
        logic            ubx_fields;
        longint unsigned stamp;
        r = '0;
        ubx_fields = 1'b0;
        if (frame_pos < 4) begin
            r.frame_status = ST_SHORT;
        end else if (first_byte == SYNC_ONE) begin
            if (sync_byte != SYNC_TWO) begin
                r.frame_status = ST_SYNC;
            end else if (frame_pos < 8) begin
                r.frame_status = ST_SHORT;
            end else begin
                ubx_fields = 1'b1;
                if (32'(decl_len) + 32'd8 > frame_pos) begin
                    r.frame_status = ST_OVERRUN;
                end else if (check_bytes[7:0] != sum_a || check_bytes[15:8] != sum_b) begin
                    r.frame_status = ST_CHECK;
                end else begin
                    r.frame_status = ST_OK;
                    if (rx_class == CLASS_TIM && msg_id == ID_TP && decl_len >= 16'd14) begin
                        stamp = EPOCH_OFFSET_US + 64'(gps_week) * WEEK_US
                              + 64'(tow_ms) * MS_US;
                        r.time_valid  = 1'b1;
                        r.gps_time_us = stamp[55:0];
                    end
                end
            end
        end else if (first_byte == NMEA_START) begin
            r.frame_status = ST_NMEA;
        end else begin
            r.frame_status = ST_UNKNOWN;
        end
        r.frame_length = 7'(frame_pos);
        if (ubx_fields) begin
            r.message_class  = rx_class;
            r.message_id     = msg_id;
            r.payload_length = decl_len;
        end
        return r;
    endfunction

    // one received byte: discard at the size limit, close on a delimiter, else capture
    task automatic take_rx_byte(input logic [7:0] b);
        if (frame_pos + 1 >= MAX_BYTES) begin
            clear_capture();
        end else if ((b == SYNC_ONE || b == NMEA_START) && frame_pos >= 1) begin
            report_q.push_back(frame_report());
            clear_capture();
            absorb_byte(b);
        end else begin
            absorb_byte(b);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_total++;
        end
    endtask

    // compare a report transaction against the oldest prediction
    task automatic check_report();
        t_result want;
        if (report_q.size() == 0) begin
            $error("frame report with no closed frame pending: tdata 0x%0h tuser 0x%0h",
                   i_rep_data, i_rep_user);
            mismatch_total++;
        end else begin
            want = report_q.pop_front();
            check_field("frame_status", 64'(want.frame_status), 64'(i_rep_user[2:0]));
            check_field("frame_length", 64'(want.frame_length), 64'(i_rep_data[6:0]));
            check_field("message_class", 64'(want.message_class), 64'(i_rep_data[14:7]));
            check_field("message_id", 64'(want.message_id), 64'(i_rep_data[22:15]));
            check_field("payload_length", 64'(want.payload_length), 64'(i_rep_data[38:23]));
            check_field("time_valid", 64'(want.time_valid), 64'(i_rep_user[3]));
            check_field("gps_time_us", 64'(want.gps_time_us), 64'(i_rep_data[94:39]));
        end
    endtask

    // watch both channels on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_capture();
            report_q.delete();
        end else begin
            if (i_rx_valid && i_rx_ready)
                take_rx_byte(i_rx_data);
            if (i_rep_valid && i_rep_ready)
                check_report();
        end
        pending_reports = report_q.size();
    end

endmodule

// ===== verif/tb_ubx_frame_receiver_time_extract.sv =====
// Testbench top for the UBX/NMEA frame receiver: drives well-formed, damaged and noisy
// frames byte by byte with random gaps and stalls, and gives the verdict.
// Depends on ubxte_pkg, ubx_frame_receiver_time_extract and ubxte_frame_report_checker.
module tb_ubx_frame_receiver_time_extract;

    import ubxte_pkg::*;

    localparam int RANDOM_BYTES = 920;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {
        FR_GOOD,
        FR_TIME,
        FR_BAD_SUM,
        FR_OVERRUN,
        FR_TRAILING,
        FR_NMEA,
        FR_BAD_SYNC,
        FR_SHORT_UBX,
        FR_NOISE,
        FR_OVERSIZE
    } t_frame_kind;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [6:0] frame_length, [14:7] message_class, [22:15] message_id,
    // [38:23] payload_length, [94:39] gps_time_us, [95] zero
    logic [95:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;   // [2:0] frame_status, [3] time_valid

    int fail_count;
    int reports_pending;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int bytes_sent = 0;

    logic [7:0] payload_q[$];
    logic [7:0] frame_q[$];

    ubx_frame_receiver_time_extract dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ubxte_frame_report_checker u_report_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_rx_valid   (s_axis_tvalid),
        .i_rx_ready   (s_axis_tready),
        .i_rx_data    (s_axis_tdata),
        .i_rep_valid  (m_axis_tvalid),
        .i_rep_ready  (m_axis_tready),
        .i_rep_data   (m_axis_tdata),
        .i_rep_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (reports_pending)
    );

    // clock
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // report receiver with random stalls
    always @(negedge clk) begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // any byte except the two frame delimiters
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == SYNC_ONE || b == NMEA_START);
        return b;
    endfunction

    function automatic bit framing_inside();
        for (int i = 1; i < frame_q.size(); i++)
            if (frame_q[i] == SYNC_ONE || frame_q[i] == NMEA_START)
                return 1'b1;
        return 1'b0;
    endfunction

    // one byte transaction, with random idle cycles ahead of it
    task automatic send_rx_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_rx_byte(frame_q[i]);
    endtask

    // hold off the sender until every closed frame has been reported
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (reports_pending != 0) @(negedge clk);
    endtask

    // ubx frame with tim-tp fields at their offsets, redrawn while a delimiter hides in it
    task automatic form_ubx(input logic [7:0] cls, input logic [7:0] mid, input int pl,
                            input logic [31:0] tow, input logic [15:0] week);
        int         tries;
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        tries = 0;
        do begin
            payload_q.delete();
            for (int i = 0; i < pl; i++) begin
                if (i < 4)
                    payload_q.push_back(tow[8*i +: 8]);
                else if (i == 12)
                    payload_q.push_back(week[7:0]);
                else if (i == 13)
                    payload_q.push_back(week[15:8]);
                else
                    payload_q.push_back(plain_byte());
            end
            frame_q.delete();
            frame_q.push_back(SYNC_ONE);
            frame_q.push_back(SYNC_TWO);
            frame_q.push_back(cls);
            frame_q.push_back(mid);
            frame_q.push_back(8'(pl));
            frame_q.push_back(8'(pl >> 8));
            for (int i = 0; i < payload_q.size(); i++)
                frame_q.push_back(payload_q[i]);
            ck_a = '0;
            ck_b = '0;
            for (int i = 2; i < frame_q.size(); i++) begin
                ck_a = ck_a + frame_q[i];
                ck_b = ck_b + ck_a;
            end
            frame_q.push_back(ck_a);
            frame_q.push_back(ck_b);
            tries++;
        end while (framing_inside() && tries < 20);
    endtask

    function automatic logic [31:0] plain_word();
        return {plain_byte(), plain_byte(), plain_byte(), plain_byte()};
    endfunction

    // idling mix of each quarter of the random part
    task automatic set_phase(input int phase);
        case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
            default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
        endcase
    endtask

    // one random frame of a randomly chosen kind
    task automatic send_random_frame();
        int          roll;
        int          pl;
        int          n;
        logic [15:0] decl;
        t_frame_kind kind;
        roll = $urandom_range(0, 99);
        if (roll < 30)      kind = FR_GOOD;
        else if (roll < 48) kind = FR_TIME;
        else if (roll < 56) kind = FR_BAD_SUM;
        else if (roll < 62) kind = FR_OVERRUN;
        else if (roll < 67) kind = FR_TRAILING;
        else if (roll < 75) kind = FR_NMEA;
        else if (roll < 80) kind = FR_BAD_SYNC;
        else if (roll < 85) kind = FR_SHORT_UBX;
        else if (roll < 95) kind = FR_NOISE;
        else                kind = FR_OVERSIZE;
        frame_q.delete();
        case (kind)
            FR_GOOD, FR_BAD_SUM, FR_OVERRUN, FR_TRAILING: begin
                // mostly short payloads, now and then one near the size limit
                pl = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 119)
                                                  : $urandom_range(0, 14);
                if (pl == int'(NMEA_START))
                    pl++;
                form_ubx(plain_byte(), plain_byte(), pl, plain_word(),
                         {plain_byte(), plain_byte()});
                if (kind == FR_BAD_SUM) begin
                    n = frame_q.size() - 1 - $urandom_range(0, 1);
                    frame_q[n] = frame_q[n] ^ 8'($urandom_range(1, 255));
                end else if (kind == FR_OVERRUN) begin
                    decl = ($urandom_range(0, 1) == 0) ? 16'(pl + $urandom_range(1, 8))
                                                       : 16'($urandom_range(pl + 1, 65535));
                    frame_q[4] = decl[7:0];
                    frame_q[5] = decl[15:8];
                end else if (kind == FR_TRAILING) begin
                    repeat ($urandom_range(1, 6)) frame_q.push_back(plain_byte());
                end
            end
            FR_TIME: begin
                pl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 13)
                                                 : $urandom_range(14, 24);
                form_ubx(CLASS_TIM, ID_TP, pl, plain_word(), {plain_byte(), plain_byte()});
            end
            FR_NMEA: begin
                frame_q.push_back(NMEA_START);
                repeat ($urandom_range(0, 40)) frame_q.push_back(plain_byte());
            end
            FR_BAD_SYNC: begin
                frame_q.push_back(SYNC_ONE);
                do
                    frame_q.push_back(plain_byte());
                while (frame_q[1] == SYNC_TWO && frame_q.pop_back() == SYNC_TWO);
                repeat ($urandom_range(0, 10)) frame_q.push_back(plain_byte());
            end
            FR_SHORT_UBX: begin
                frame_q.push_back(SYNC_ONE);
                frame_q.push_back(SYNC_TWO);
                repeat ($urandom_range(0, 5)) frame_q.push_back(plain_byte());
            end
            FR_NOISE: begin
                repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                // near or past the size limit: reported up to 126 bytes, dropped beyond
                frame_q.push_back(SYNC_ONE);
                repeat ($urandom_range(124, 132)) frame_q.push_back(plain_byte());
            end
        endcase
        send_frame();
    endtask

    // stimulus
    initial begin
        int random_start;
        int phase;
        int next_phase;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unknown start right after reset, closed by the next frame
        frame_q = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        send_frame();
        // nmea too short, then a plain nmea frame
        frame_q = '{NMEA_START, 8'h41};
        send_frame();
        frame_q = '{NMEA_START, 8'h47, 8'h50, 8'h5A};
        send_frame();
        // bad second sync byte, then a ubx frame too short to hold a header
        frame_q = '{SYNC_ONE, 8'h00, 8'hFF, 8'h01};
        send_frame();
        frame_q = '{SYNC_ONE, SYNC_TWO, CLASS_TIM, ID_TP, 8'h00};
        send_frame();
        // class and id extremes with an empty payload
        form_ubx(8'hFF, 8'h00, 0, '0, '0);
        send_frame();
        // tim-tp with the largest and the smallest timestamp
        form_ubx(CLASS_TIM, ID_TP, 14, 32'hFFFF_FFFF, 16'hFFFF);
        send_frame();
        form_ubx(CLASS_TIM, ID_TP, 16, '0, '0);
        send_frame();
        // tim-tp with a payload one byte short of the time fields
        form_ubx(CLASS_TIM, ID_TP, 13, 32'h0102_0304, 16'h0506);
        send_frame();
        // largest declared length against a short frame
        form_ubx(8'h01, 8'h02, 2, 32'h0000_1111, '0);
        frame_q[4] = 8'hFF;
        frame_q[5] = 8'hFF;
        send_frame();
        // corrupted second check byte
        form_ubx(8'h01, 8'h07, 4, 32'h8040_2010, '0);
        frame_q[frame_q.size()-1] = frame_q[frame_q.size()-1] ^ 8'h80;
        send_frame();
        // bytes after the check bytes
        form_ubx(8'h0A, 8'h04, 0, '0, '0);
        repeat (3) frame_q.push_back(plain_byte());
        send_frame();
        // a lone delimiter makes a one-byte frame
        send_rx_byte(NMEA_START);

        random_start = bytes_sent;
        phase = 0;
        set_phase(phase);
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            next_phase = (bytes_sent - random_start) * 4 / RANDOM_BYTES;
            if (next_phase > 3)
                next_phase = 3;
            if (next_phase != phase) begin
                phase = next_phase;
                drain_reports();
                set_phase(phase);
            end
            send_random_frame();
        end
        // close the last frame so it gets reported
        send_rx_byte(NMEA_START);
        send_rx_byte(NMEA_START);

        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
